// ===== rtl/tlb_refill_with_lru_frames_defines.svh =====
// Assertion macros for the TLB refill block.
`ifndef TLB_REFILL_WITH_LRU_FRAMES_DEFINES_SVH
`define TLB_REFILL_WITH_LRU_FRAMES_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TRL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define TRL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/trl_pkg.sv =====
// Package: shared types, constants and codes for the TLB refill block.
`timescale 1ns / 1ps
package trl_pkg;
  localparam int FRAMES_DEF = 32;
  localparam int TLB_SLOTS_DEF = 4;
  localparam int PAGE_BYTES_DEF = 128;
  localparam int PAGE_W = 25;
  localparam int PID_W = 8;
  localparam int TICK_W = 32;
  localparam int SPACE_W = 26;
  localparam int ADDR_W = 32;
  localparam int FRAME_W = 5;
  localparam int SLOT_W = 2;
  localparam int CFG_W = 26;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_PID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_PAGES = 1'b1;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_ADDR_ERR = 2'd2;
  localparam logic [1:0] ST_DIRTY = 2'd3;

  localparam logic OP_REFILL = 1'b0;
  localparam logic OP_MARK = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic              valid;
    logic              dirty;
    logic [TICK_W-1:0] last_use;
  } frame_info_t;

  // Scan flag set: hit found, free found and is free.
  typedef struct packed {
    logic              hit_found;
    logic              free_found;
    logic              is_free;
  } scan_flags_t;
endpackage

// ===== rtl/trl_if.sv =====
// Valid/ready channel interfaces for items in and results out.
`timescale 1ns / 1ps
interface trl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [trl_pkg::ADDR_W-1:0]   bad_address;
  logic [trl_pkg::TICK_W-1:0]   now_ticks;
  logic [1:0]                   slot_index;
  modport source (output valid, operation, bad_address, now_ticks, slot_index, input ready);
  modport sink (input valid, operation, bad_address, now_ticks, slot_index, output ready);
endinterface

interface trl_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [trl_pkg::FRAME_W-1:0]  frame;
  logic [trl_pkg::PAGE_W-1:0]   page;
  logic [trl_pkg::SLOT_W-1:0]   tlb_slot;
  logic                         evict_valid;
  logic                         evict_writeback;
  logic [trl_pkg::PID_W-1:0]    evict_pid;
  logic [trl_pkg::PAGE_W-1:0]   evict_page;
  modport source (output valid, status, frame, page, tlb_slot, evict_valid,
                  evict_writeback, evict_pid, evict_page, input ready);
  modport sink (input valid, status, frame, page, tlb_slot, evict_valid,
                evict_writeback, evict_pid, evict_page, output ready);
endinterface

// ===== rtl/trl_frame_cell.sv =====
// One frame-table entry; a ring of these rotates past the head every scan cycle.
`timescale 1ns / 1ps
module trl_frame_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic                   load_en,
  input  trl_pkg::frame_info_t   load_info,
  input  trl_pkg::frame_info_t   prev_info,
  output trl_pkg::frame_info_t   info
);
  always_ff @(posedge clk) begin
    if (rst) begin
      info <= '0;
    end else if (load_en) begin
      info <= load_info;
    end else if (shift) begin
      info <= prev_info;
    end
  end
endmodule

// ===== rtl/tlb_refill_with_lru_frames.sv =====
// Top level: TLB refill unit with a rotating frame-table ring and LRU choice.
// Refill sequence from accept to result valid: scan all FRAMES frames, then seek to the
//   chosen frame, update it, and rotate back until frame 0 is at the head. Address
//   error: result right after the scan. Dirty mark: result directly after accept.
// One item at a time; the next item is taken only after the result is accepted.
// Synchronous reset clears all tables, TLB slots and the FIFO pointer.
`timescale 1ns / 1ps
module tlb_refill_with_lru_frames #(
  parameter int FRAMES = trl_pkg::FRAMES_DEF,
  parameter int TLB_SLOTS = trl_pkg::TLB_SLOTS_DEF,
  parameter int PAGE_BYTES = trl_pkg::PAGE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [trl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trl_pkg::CFG_W-1:0]   cfg_data,
  trl_in_if.sink                      in_ch,
  trl_out_if.source                   out_ch
);
  localparam int FI_W = $clog2(FRAMES);
  localparam int SI_W = $clog2(TLB_SLOTS);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int SH = $clog2(PAGE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_SEEK = 5'b00100,
    S_UPD = 5'b01000, S_OUT = 5'b10000
  } state_t;
  state_t state;

  logic [trl_pkg::PID_W-1:0]   current_pid;
  logic [trl_pkg::SPACE_W-1:0] space_pages;

  // Frame ring: cell 0 is the head; shifting moves cell i+1 into cell i.
  trl_pkg::frame_info_t cell_info [FRAMES];
  trl_pkg::frame_info_t head_new;
  trl_pkg::frame_info_t tail_in;
  logic                 shift;
  logic                 head_load;
  // Per-frame TLB link, kept by frame index (flops, one per frame).
  logic                 link_in [FRAMES];
  logic [SI_W-1:0]      link_slot [FRAMES];
  // Slot dirty bit owed to a frame away from the head; applied as it passes.
  logic                 cb_pending;
  logic [FI_W-1:0]      cb_frame;
  logic                 cb_dirty;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_ring
      if (g == FRAMES - 1) begin : g_tail
        trl_frame_cell u_cell (.clk, .rst, .shift, .load_en(1'b0), .load_info(head_new),
          .prev_info(tail_in), .info(cell_info[g]));
      end else if (g == 0) begin : g_head
        trl_frame_cell u_cell (.clk, .rst, .shift, .load_en(head_load), .load_info(head_new),
          .prev_info(cell_info[1]), .info(cell_info[g]));
      end else begin : g_mid
        trl_frame_cell u_cell (.clk, .rst, .shift, .load_en(1'b0), .load_info(head_new),
          .prev_info(cell_info[g+1]), .info(cell_info[g]));
      end
    end
  endgenerate

  // TLB slots
  logic [trl_pkg::PAGE_W-1:0] slot_page [TLB_SLOTS];
  logic [FI_W-1:0]            slot_frame [TLB_SLOTS];
  logic                       slot_valid [TLB_SLOTS];
  logic                       slot_dirty [TLB_SLOTS];
  logic [SI_W-1:0]            fifo_pointer;

  // Item and scan registers
  logic [trl_pkg::PAGE_W-1:0] page;
  logic [trl_pkg::TICK_W-1:0] now;
  logic [CNT_W-1:0]           cnt;     // frame index currently at head
  logic                       hit_found, free_found;
  logic [FI_W-1:0]            hit_idx, free_idx, lru_idx, target;
  logic [trl_pkg::TICK_W-1:0] lru_time;
  logic                       is_fault;

  // result registers
  logic [1:0]                 r_status;
  logic [trl_pkg::FRAME_W-1:0] r_frame;
  logic [trl_pkg::PAGE_W-1:0] r_page;
  logic [trl_pkg::SLOT_W-1:0] r_slot;
  logic                       r_ev, r_wb;
  logic [trl_pkg::PID_W-1:0]  r_epid;
  logic [trl_pkg::PAGE_W-1:0] r_epage;

  trl_pkg::frame_info_t h;
  logic [FI_W-1:0]      cidx;
  logic                 head_match;
  assign h = cell_info[0];
  assign cidx = cnt[FI_W-1:0];
  assign head_match = h.valid && h.pid == current_pid && h.page == page;

  always_comb begin
    tail_in = h;
    if (cb_pending && cidx == cb_frame) tail_in.dirty = cb_dirty;
  end

  // TLB slot choice: lowest invalid else FIFO pointer
  logic [SI_W-1:0] free_slot, s_pick;
  logic            any_free;
  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SI_W'(i);
        any_free = 1'b1;
      end
    end
    s_pick = any_free ? free_slot : fifo_pointer;
  end

  logic [SI_W-1:0] tslot;
  logic            tgt_dirty_eff, ev_link_dirty;
  assign tslot = link_slot[target];
  assign ev_link_dirty = link_in[target] ? slot_dirty[tslot] : h.dirty;
  // dirty of target frame as seen after a possible FIFO victim write-back
  logic old_frame_is_tgt;
  assign old_frame_is_tgt = slot_valid[s_pick] && slot_frame[s_pick] == target;

  assign shift = (state == S_SCAN) || (state == S_SEEK && cidx != target) ||
                 (state == S_OUT && cnt != '0);
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_comb begin
    head_new = h;
    head_load = 1'b0;
    tgt_dirty_eff = h.dirty;
    if (state == S_UPD) begin
      head_load = 1'b1;
      if (is_fault) begin
        head_new.valid = 1'b1;
        head_new.pid = current_pid;
        head_new.page = page;
      end
      if (old_frame_is_tgt) begin
        tgt_dirty_eff = slot_dirty[s_pick];
      end else if (is_fault) begin
        tgt_dirty_eff = 1'b0;
      end
      head_new.dirty = tgt_dirty_eff;
      head_new.last_use = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_pid <= '0;
      space_pages <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        trl_pkg::REG_CURRENT_PID: current_pid <= cfg_data[trl_pkg::PID_W-1:0];
        trl_pkg::REG_SPACE_PAGES: space_pages <= cfg_data[trl_pkg::SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fifo_pointer <= '0;
      cnt <= '0;
      cb_pending <= 1'b0;
      cb_frame <= '0;
      cb_dirty <= 1'b0;
      for (int i = 0; i < TLB_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_dirty[i] <= 1'b0;
        slot_page[i] <= '0;
        slot_frame[i] <= '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
        link_in[i] <= 1'b0;
        link_slot[i] <= '0;
      end
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (shift && cb_pending && cidx == cb_frame) cb_pending <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            r_page <= '0; r_frame <= '0; r_slot <= '0;
            r_ev <= 1'b0; r_wb <= 1'b0; r_epid <= '0; r_epage <= '0;
            if (in_ch.operation == trl_pkg::OP_MARK) begin
              if (32'(in_ch.slot_index) < TLB_SLOTS)
                slot_dirty[SI_W'(in_ch.slot_index)] <= 1'b1;
              r_status <= trl_pkg::ST_DIRTY;
              r_slot <= in_ch.slot_index;
              state <= S_OUT;
            end else begin
              page <= trl_pkg::PAGE_W'(in_ch.bad_address >> SH);
              now <= in_ch.now_ticks;
              cnt <= '0;
              hit_found <= 1'b0;
              free_found <= 1'b0;
              lru_idx <= '0;
              lru_time <= '1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!hit_found && head_match) begin
            hit_found <= 1'b1; hit_idx <= cidx;
          end
          if (!free_found && !h.valid) begin
            free_found <= 1'b1; free_idx <= cidx;
          end
          if (cnt == '0 || h.last_use < lru_time) begin
            lru_time <= h.last_use; lru_idx <= cidx;
          end
          if (cnt == CNT_W'(FRAMES - 1)) begin
            cnt <= '0;
            state <= S_SEEK;
            r_page <= page;
            if (hit_found || head_match) begin
              is_fault <= 1'b0;
              target <= hit_found ? hit_idx : cidx;
            end else if ({1'b0, page} >= space_pages) begin
              r_status <= trl_pkg::ST_ADDR_ERR;
              state <= S_OUT;
            end else begin
              is_fault <= 1'b1;
              target <= free_found ? free_idx
                      : (!h.valid ? cidx
                      : ((h.last_use < lru_time) ? cidx : lru_idx));
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SEEK: begin
          if (cidx == target) begin
            state <= S_UPD;
            if (is_fault && h.valid) begin
              r_ev <= 1'b1;
              r_wb <= ev_link_dirty;
              r_epid <= h.pid;
              r_epage <= h.page;
              if (link_in[target]) slot_valid[tslot] <= 1'b0;
            end
          end else begin
            cnt <= (cnt == CNT_W'(FRAMES - 1)) ? '0 : cnt + 1'b1;
          end
        end
        S_UPD: begin
          // old frame of a reused slot takes back the slot's dirty bit
          if (slot_valid[s_pick] && slot_frame[s_pick] != target) begin
            link_in[slot_frame[s_pick]] <= 1'b0;
            cb_pending <= 1'b1;
            cb_frame <= slot_frame[s_pick];
            cb_dirty <= slot_dirty[s_pick];
          end
          slot_page[s_pick] <= page;
          slot_frame[s_pick] <= target;
          slot_valid[s_pick] <= 1'b1;
          slot_dirty[s_pick] <= tgt_dirty_eff;
          link_in[target] <= 1'b1;
          link_slot[target] <= s_pick;
          fifo_pointer <= (32'(s_pick) == TLB_SLOTS - 1) ? '0 : s_pick + 1'b1;
          r_status <= is_fault ? trl_pkg::ST_FAULT : trl_pkg::ST_HIT;
          r_frame <= trl_pkg::FRAME_W'(target);
          r_slot <= trl_pkg::SLOT_W'(s_pick);
          state <= S_OUT;
        end
        S_OUT: begin
          // wait for ring to return to frame 0 at head before next item
          if (cnt != '0) begin
            cnt <= (cnt == CNT_W'(FRAMES - 1)) ? '0 : cnt + 1'b1;
          end else if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring keeps rotating in S_OUT until the head is frame 0
  // (see shift)
  assign out_ch.status = r_status;
  assign out_ch.frame = r_frame;
  assign out_ch.page = r_page;
  assign out_ch.tlb_slot = r_slot;
  assign out_ch.evict_valid = r_ev;
  assign out_ch.evict_writeback = r_wb;
  assign out_ch.evict_pid = r_epid;
  assign out_ch.evict_page = r_epage;
endmodule

// ===== rtl/trl_checker.sv =====
// Port-level checker for the TLB refill block, bound to the top level.
`timescale 1ns / 1ps
`include "tlb_refill_with_lru_frames_defines.svh"
module trl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       evict_valid,
  input logic       evict_writeback
);
  `TRL_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `TRL_ASSERT_IMP(a_wb, clk, rst, out_valid && evict_writeback, evict_valid, "writeback without victim")
  `TRL_ASSERT_IMP(a_ev, clk, rst, out_valid && evict_valid, status == trl_pkg::ST_FAULT, "evict on non-fault")
  `TRL_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "second item taken while busy")
endmodule

bind tlb_refill_with_lru_frames trl_checker u_trl_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .evict_valid(out_ch.evict_valid), .evict_writeback(out_ch.evict_writeback)
);
